/* rtl/rv32_lsa_pkg.sv */
// Types and constants shared by the RV32IA load/store/atomic unit.
// Depends on nothing; imported by rv32_load_store_atomic_unit.
package rv32_lsa_pkg;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_READ,
        S_EXEC
    } t_state;

    // Instruction classes
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_MISC  = 2'd1;
    localparam logic [1:0] CMD_STORE = 2'd2;
    localparam logic [1:0] CMD_AMO   = 2'd3;

    // funct3 width / fence codes
    localparam logic [2:0] F3_B       = 3'd0;
    localparam logic [2:0] F3_H       = 3'd1;
    localparam logic [2:0] F3_W       = 3'd2;
    localparam logic [2:0] F3_BU      = 3'd4;
    localparam logic [2:0] F3_HU      = 3'd5;
    localparam logic [2:0] F3_FENCE_I = 3'd1;

    // Atomic operation codes, funct7[6:2]
    localparam logic [4:0] AMO_ADD  = 5'h00;
    localparam logic [4:0] AMO_SWAP = 5'h01;
    localparam logic [4:0] AMO_LR   = 5'h02;
    localparam logic [4:0] AMO_SC   = 5'h03;
    localparam logic [4:0] AMO_XOR  = 5'h04;
    localparam logic [4:0] AMO_OR   = 5'h08;
    localparam logic [4:0] AMO_AND  = 5'h0C;
    localparam logic [4:0] AMO_MIN  = 5'h10;
    localparam logic [4:0] AMO_MAX  = 5'h14;
    localparam logic [4:0] AMO_MINU = 5'h18;
    localparam logic [4:0] AMO_MAXU = 5'h1C;

    // Exception causes
    localparam logic [1:0] CAUSE_ILLEGAL    = 2'd0;
    localparam logic [1:0] CAUSE_LOAD_MISAL = 2'd1;
    localparam logic [1:0] CAUSE_STORE_MISAL = 2'd2;

    // Word address width of a byte address
    localparam int unsigned WORD_ADDR_W = 30;

endpackage

/* rtl/rv32_load_store_atomic_unit.sv */
// RV32IA load/store/atomic unit with a private single-port data memory.
// Depends on rv32_lsa_pkg (state type, opcode and cause constants).
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  input    | i_in_valid / o_in_ready    | command, funct3, funct7, rs2_field, base,
//           |                            | offset, src_data, raw_instruction
//  output   | o_out_valid / i_out_ready  | writeback enable/data, exception
//           |                            | valid/cause/value
//
// An instruction is accepted, reads memory, then executes and writes back when
// MEM_WORDS is a power of two; otherwise a reduction state before the read takes
// the word index modulo MEM_WORDS (reciprocal multiply, multiply back, subtract).
// Synchronous active-low reset clears the sequencer, reservation and output valid.
// A finished result waits in the output register; a new transaction is taken
// meanwhile, and only the execute step stalls while the output is still full.
module rv32_load_store_atomic_unit
    import rv32_lsa_pkg::*;
#(
    parameter int unsigned MEM_WORDS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [2:0]  i_funct3,
    input  logic [6:0]  i_funct7,
    input  logic [4:0]  i_rs2_field,
    input  logic [31:0] i_base_value,
    input  logic [11:0] i_offset,
    input  logic [31:0] i_src_data,
    input  logic [31:0] i_raw_instruction,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_writeback_enable,
    output logic [31:0] o_writeback_data,
    output logic        o_exception_valid,
    output logic [1:0]  o_exception_cause,
    output logic [31:0] o_exception_value
);

    localparam int unsigned AW      = $clog2(MEM_WORDS);
    localparam bit          IS_POW2 = (MEM_WORDS & (MEM_WORDS - 1)) == 0;
    // Word index / MEM_WORDS == (index * RECIP) >> MOD_SH for any 30-bit index
    localparam int unsigned MOD_SH  = WORD_ADDR_W + AW;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << MOD_SH) + 64'(MEM_WORDS) - 64'd1)
                                         / 64'(MEM_WORDS);
    localparam logic [31:0] RECIP   = RECIP_FULL[31:0];

    // Sequencer
    t_state r_state, n_state;

    // Captured transaction
    logic [1:0]             r_command;
    logic [2:0]             r_funct3;
    logic [4:0]             r_amo_op;
    logic                   r_rs2_nz;
    logic [31:0]            r_addr;
    logic [31:0]            r_src;
    logic [31:0]            r_raw;
    logic [WORD_ADDR_W-1:0] r_word;
    logic [WORD_ADDR_W-1:0] r_quot;
    logic                   r_mod_ph;

    // Memory and reservation
    logic [31:0] r_mem [MEM_WORDS];
    logic [31:0] r_rdata;
    logic        r_resv_valid;
    logic [31:0] r_resv_addr;

    // Output register
    logic        r_out_valid;
    logic        r_wb_en;
    logic [31:0] r_wb;
    logic        r_exc;
    logic [1:0]  r_cause;
    logic [31:0] r_evalue;

    // Control strobes
    logic accept;
    logic exec_done;
    logic mem_rd;

    // Execute results
    logic        x_exc;
    logic [1:0]  x_cause;
    logic [31:0] x_evalue;
    logic        x_wb_en;
    logic [31:0] x_wb;
    logic        x_we;
    logic [31:0] x_wdata;
    logic        x_resv_set;
    logic        x_resv_clr;
    logic        x_known;
    logic [7:0]  x_byte;
    logic [15:0] x_half;

    logic [31:0] n_addr;
    logic [AW-1:0] mem_index;
    logic [61:0]            mod_prod;
    logic [WORD_ADDR_W-1:0] mod_back;

    assign mem_index = r_word[AW-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = IS_POW2 ? S_READ : S_MOD;
                end
            end
            S_MOD: begin
                if (!r_mod_ph) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_EXEC;
            S_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_ready = 1'b0;
        mem_rd     = 1'b0;
        exec_done  = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_MOD:   ;
            S_READ:  mem_rd = 1'b1;
            S_EXEC:  exec_done = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Effective address: atomics use the base alone
    assign n_addr = (i_command == CMD_AMO) ? i_base_value
                  : i_base_value + {{20{i_offset[11]}}, i_offset};

    // Remainder datapath: quotient by reciprocal, then multiply back
    assign mod_prod = 62'(r_word) * 62'(RECIP);
    assign mod_back = WORD_ADDR_W'(r_quot * MEM_WORDS);

    // Capture and word-index reduction (reciprocal multiply, then subtract)
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_command <= i_command;
            r_funct3  <= i_funct3;
            r_amo_op  <= i_funct7[6:2];
            r_rs2_nz  <= i_rs2_field != 5'd0;
            r_addr    <= n_addr;
            r_src     <= i_src_data;
            r_raw     <= i_raw_instruction;
            r_word    <= n_addr[31:2];
            r_mod_ph  <= 1'b1;
        end else if (r_state == S_MOD) begin
            if (r_mod_ph) begin
                r_quot <= WORD_ADDR_W'(mod_prod >> MOD_SH);
            end else begin
                r_word <= r_word - mod_back;
            end
            r_mod_ph <= 1'b0;
        end
    end

    // Data memory: one port, read in S_READ, written at the end of S_EXEC
    always_ff @(posedge i_clk) begin
        if (exec_done && x_we) begin
            r_mem[mem_index] <= x_wdata;
        end
        if (mem_rd) begin
            r_rdata <= r_mem[mem_index];
        end
    end

    // Lane extraction
    always_comb begin
        unique case (r_addr[1:0])
            2'd0: x_byte = r_rdata[7:0];
            2'd1: x_byte = r_rdata[15:8];
            2'd2: x_byte = r_rdata[23:16];
            2'd3: x_byte = r_rdata[31:24];
            default: x_byte = r_rdata[7:0];
        endcase
        x_half = r_addr[1] ? r_rdata[31:16] : r_rdata[15:0];
    end

    // Known atomic operations
    always_comb begin
        unique case (r_amo_op)
            AMO_ADD, AMO_SWAP, AMO_LR, AMO_SC, AMO_XOR, AMO_OR, AMO_AND,
            AMO_MIN, AMO_MAX, AMO_MINU, AMO_MAXU: x_known = 1'b1;
            default: x_known = 1'b0;
        endcase
    end

    // Execute: decode, exceptions, writeback and memory update
    always_comb begin
        x_exc      = 1'b0;
        x_cause    = CAUSE_ILLEGAL;
        x_evalue   = 32'd0;
        x_wb_en    = 1'b0;
        x_wb       = 32'd0;
        x_we       = 1'b0;
        x_wdata    = r_rdata;
        x_resv_set = 1'b0;
        x_resv_clr = 1'b0;
        unique case (r_command)
            CMD_LOAD: begin
                unique case (r_funct3)
                    F3_B, F3_BU: begin
                        x_wb_en = 1'b1;
                        x_wb    = {{24{(r_funct3 == F3_B) && x_byte[7]}}, x_byte};
                    end
                    F3_H, F3_HU: begin
                        if (r_addr[0]) begin
                            x_exc    = 1'b1;
                            x_cause  = CAUSE_LOAD_MISAL;
                            x_evalue = r_addr;
                        end else begin
                            x_wb_en = 1'b1;
                            x_wb    = {{16{(r_funct3 == F3_H) && x_half[15]}}, x_half};
                        end
                    end
                    F3_W: begin
                        if (r_addr[1:0] != 2'd0) begin
                            x_exc    = 1'b1;
                            x_cause  = CAUSE_LOAD_MISAL;
                            x_evalue = r_addr;
                        end else begin
                            x_wb_en = 1'b1;
                            x_wb    = r_rdata;
                        end
                    end
                    default: begin
                        x_exc    = 1'b1;
                        x_evalue = r_raw;
                    end
                endcase
            end
            CMD_MISC: begin
                // FENCE and FENCE.I retire as no-ops
                if (r_funct3 > F3_FENCE_I) begin
                    x_exc    = 1'b1;
                    x_evalue = r_raw;
                end
            end
            CMD_STORE: begin
                unique case (r_funct3)
                    F3_B: begin
                        x_we = 1'b1;
                        unique case (r_addr[1:0])
                            2'd0: x_wdata = {r_rdata[31:8], r_src[7:0]};
                            2'd1: x_wdata = {r_rdata[31:16], r_src[7:0], r_rdata[7:0]};
                            2'd2: x_wdata = {r_rdata[31:24], r_src[7:0], r_rdata[15:0]};
                            2'd3: x_wdata = {r_src[7:0], r_rdata[23:0]};
                            default: x_wdata = r_rdata;
                        endcase
                    end
                    F3_H: begin
                        if (r_addr[0]) begin
                            x_exc    = 1'b1;
                            x_cause  = CAUSE_STORE_MISAL;
                            x_evalue = r_addr;
                        end else begin
                            x_we    = 1'b1;
                            x_wdata = r_addr[1] ? {r_src[15:0], r_rdata[15:0]}
                                                : {r_rdata[31:16], r_src[15:0]};
                        end
                    end
                    F3_W: begin
                        if (r_addr[1:0] != 2'd0) begin
                            x_exc    = 1'b1;
                            x_cause  = CAUSE_STORE_MISAL;
                            x_evalue = r_addr;
                        end else begin
                            x_we    = 1'b1;
                            x_wdata = r_src;
                        end
                    end
                    default: begin
                        x_exc    = 1'b1;
                        x_evalue = r_raw;
                    end
                endcase
            end
            CMD_AMO: begin
                priority if (!x_known || (r_amo_op == AMO_LR && r_rs2_nz)) begin
                    x_exc    = 1'b1;
                    x_evalue = r_raw;
                end else if (r_addr[1:0] != 2'd0) begin
                    x_exc    = 1'b1;
                    x_cause  = CAUSE_STORE_MISAL;
                    x_evalue = r_addr;
                end else if (r_amo_op == AMO_LR) begin
                    x_resv_set = 1'b1;
                    x_wb_en    = 1'b1;
                    x_wb       = r_rdata;
                end else if (r_amo_op == AMO_SC) begin
                    x_resv_clr = 1'b1;
                    x_wb_en    = 1'b1;
                    if (r_resv_valid && r_resv_addr == r_addr) begin
                        x_we    = 1'b1;
                        x_wdata = r_src;
                    end else begin
                        x_wb = 32'd1;
                    end
                end else begin
                    // Read-modify-write: old word goes back to rd
                    x_we    = 1'b1;
                    x_wb_en = 1'b1;
                    x_wb    = r_rdata;
                    unique case (r_amo_op)
                        AMO_SWAP: x_wdata = r_src;
                        AMO_ADD:  x_wdata = r_rdata + r_src;
                        AMO_XOR:  x_wdata = r_rdata ^ r_src;
                        AMO_AND:  x_wdata = r_rdata & r_src;
                        AMO_OR:   x_wdata = r_rdata | r_src;
                        AMO_MIN:  x_wdata = ($signed(r_src) < $signed(r_rdata)) ? r_src
                                                                                 : r_rdata;
                        AMO_MAX:  x_wdata = ($signed(r_rdata) < $signed(r_src)) ? r_src
                                                                                 : r_rdata;
                        AMO_MINU: x_wdata = (r_src < r_rdata) ? r_src : r_rdata;
                        default:  x_wdata = (r_rdata < r_src) ? r_src : r_rdata;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // Reservation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resv_valid <= 1'b0;
            r_resv_addr  <= 32'd0;
        end else if (exec_done) begin
            if (x_resv_set) begin
                r_resv_valid <= 1'b1;
                r_resv_addr  <= r_addr;
            end else if (x_resv_clr) begin
                r_resv_valid <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_done) begin
            r_wb_en  <= x_wb_en;
            r_wb     <= x_wb;
            r_exc    <= x_exc;
            r_cause  <= x_cause;
            r_evalue <= x_evalue;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_writeback_enable = r_wb_en;
    assign o_writeback_data   = r_wb;
    assign o_exception_valid  = r_exc;
    assign o_exception_cause  = r_cause;
    assign o_exception_value  = r_evalue;

endmodule
